// File: rtl/core/i2c_master_byte_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// i2c master byte sequencer assertion macros
// concurrent assertion wrappers for the core rtl
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define I2CBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define I2CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// types and constants shared by the i2c master byte sequencer core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbs_pkg;

  // command codes
  localparam logic [2:0] OpNone  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop  = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  // register indexes (word address bit)
  localparam logic RegTicksPerUs = 1'b0;
  localparam logic RegAckTimeout = 1'b1;

  // register reset values
  localparam logic [9:0] TicksPerUsReset = 10'd50;
  localparam logic [9:0] AckTimeoutReset = 10'd250;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } result_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

endpackage

// File: rtl/core/i2cbs_cfg.sv
// ----------------------------------------------------------------------------
// i2cbs_cfg
// apb register file: delay unit length and acknowledge timeout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbs_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [9:0]  ticks_per_us_o,
  output logic [9:0]  ack_timeout_o
);
  import i2cbs_pkg::*;

  logic [9:0] ticks_q, ticks_d;
  logic [9:0] tmo_q, tmo_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    ticks_d = ticks_q;
    tmo_d   = tmo_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegTicksPerUs: ticks_d = pwdata[9:0];
        RegAckTimeout: tmo_d   = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTicksPerUs: prdata = {22'd0, ticks_q};
      RegAckTimeout: prdata = {22'd0, tmo_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TicksPerUsReset;
      tmo_q   <= AckTimeoutReset;
    end else begin
      ticks_q <= ticks_d;
      tmo_q   <= tmo_d;
    end
  end

  assign ticks_per_us_o = ticks_q;
  assign ack_timeout_o  = tmo_q;

endmodule

// File: rtl/core/i2cbs_seq.sv
// ----------------------------------------------------------------------------
// i2cbs_seq
// pin sequencer state and one-tick next-state logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_byte_sequencer_core_defines.svh"

module i2cbs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cbs_pkg::item_t  item_i,
  input  logic [9:0]        ticks_per_us_i,
  input  logic [9:0]        ack_timeout_i,
  output i2cbs_pkg::result_t res_o
);
  import i2cbs_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SStA    = 4'd1;
  localparam logic [3:0] SStB    = 4'd2;
  localparam logic [3:0] SSpA    = 4'd3;
  localparam logic [3:0] SSpB    = 4'd4;
  localparam logic [3:0] SWrLo   = 4'd5;
  localparam logic [3:0] SWrHi   = 4'd6;
  localparam logic [3:0] SWrFall = 4'd7;
  localparam logic [3:0] SAkRel  = 4'd8;
  localparam logic [3:0] SAkHi   = 4'd9;
  localparam logic [3:0] SAkPoll = 4'd10;
  localparam logic [3:0] SRdLo   = 4'd11;
  localparam logic [3:0] SRdHi   = 4'd12;
  localparam logic [3:0] SRaLo   = 4'd13;
  localparam logic [3:0] SRaHi   = 4'd14;

  logic [3:0] state_q, state_d;
  logic [3:0] bc_q, bc_d;
  logic [9:0] tick_q, tick_d;
  logic [2:0] units_q, units_d;
  logic [7:0] shift_q, shift_d;
  logic [9:0] poll_q, poll_d;
  pins_t      pin_q, pin_d;
  logic [7:0] rx_q, rx_d;
  logic       aerr_q, aerr_d;
  logic       ackc_q, ackc_d;

  logic [9:0] tpu;
  logic [9:0] tick_inc;
  logic [2:0] units_dec;
  logic [2:0] ent_units;
  logic [3:0] ent_step;
  logic       ent;
  logic       fin;

  // zero unit length behaves as one tick
  assign tpu = (ticks_per_us_i == 10'd0) ? 10'd1 : ticks_per_us_i;

  always_comb begin
    state_d   = state_q;
    bc_d      = bc_q;
    tick_d    = tick_q;
    units_d   = units_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    pin_d     = pin_q;
    rx_d      = rx_q;
    aerr_d    = aerr_q;
    ackc_d    = ackc_q;
    ent       = 1'b0;
    ent_step  = SIdle;
    ent_units = 3'd0;
    fin       = 1'b0;
    tick_inc  = tick_q + 10'd1;
    units_dec = (units_q != 3'd0) ? units_q - 3'd1 : units_q;

    if (step_i) begin
      if (state_q == SIdle) begin
        bc_d = 4'd0;
        case (item_i.op)
          OpStart: begin
            ent      = 1'b1;
            ent_step = SStA;
          end
          OpStop: begin
            ent      = 1'b1;
            ent_step = SSpA;
          end
          OpWrite: begin
            shift_d  = item_i.tx_byte;
            ent      = 1'b1;
            ent_step = SWrLo;
          end
          OpRead: begin
            ackc_d   = item_i.send_ack;
            shift_d  = 8'd0;
            ent      = 1'b1;
            ent_step = SRdLo;
          end
          default: ;
        endcase
      end else if (state_q == SAkPoll) begin
        if (!item_i.sda_in) begin
          pin_d.scl = 1'b0;
          aerr_d    = 1'b0;
          fin       = 1'b1;
        end else if (poll_q >= ack_timeout_i) begin
          // no acknowledge: flag it and release the bus with a stop
          aerr_d   = 1'b1;
          ent      = 1'b1;
          ent_step = SSpA;
        end else begin
          poll_d = poll_q + 10'd1;
        end
      end else begin
        tick_d = tick_inc;
        if (tick_inc >= tpu) begin
          tick_d  = 10'd0;
          units_d = units_dec;
          if (units_dec == 3'd0) begin
            unique case (state_q)
              SStA: begin
                ent      = 1'b1;
                ent_step = SStB;
              end
              SStB: begin
                pin_d.scl = 1'b0;
                fin       = 1'b1;
              end
              SSpA: begin
                ent      = 1'b1;
                ent_step = SSpB;
              end
              SWrLo: begin
                ent      = 1'b1;
                ent_step = SWrHi;
              end
              SWrHi: begin
                ent      = 1'b1;
                ent_step = SWrFall;
              end
              SWrFall: begin
                bc_d     = bc_q + 4'd1;
                ent      = 1'b1;
                ent_step = (bc_d < 4'd8) ? SWrLo : SAkRel;
              end
              SAkRel: begin
                ent      = 1'b1;
                ent_step = SAkHi;
              end
              SAkHi: begin
                ent      = 1'b1;
                ent_step = SAkPoll;
              end
              SRdLo: begin
                ent      = 1'b1;
                ent_step = SRdHi;
              end
              SRdHi: begin
                bc_d     = bc_q + 4'd1;
                ent      = 1'b1;
                ent_step = (bc_d < 4'd8) ? SRdLo : SRaLo;
              end
              SRaLo: begin
                ent      = 1'b1;
                ent_step = SRaHi;
              end
              SRaHi: begin
                pin_d.scl = 1'b0;
                rx_d      = shift_q;
                fin       = 1'b1;
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end

      if (fin) begin
        state_d = SIdle;
        units_d = 3'd0;
        tick_d  = 10'd0;
      end

      if (ent) begin
        // entry actions of the next phase
        case (ent_step)
          SStA: begin
            pin_d     = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
            ent_units = 3'd4;
          end
          SStB: begin
            pin_d     = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
            ent_units = 3'd4;
          end
          SSpA: begin
            pin_d     = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
            ent_units = 3'd4;
          end
          SSpB: begin
            pin_d     = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
            ent_units = 3'd4;
          end
          SWrLo: begin
            pin_d     = '{drv: 1'b1, sda: shift_d[7], scl: 1'b0};
            shift_d   = {shift_d[6:0], 1'b0};
            ent_units = 3'd2;
          end
          SWrHi: begin
            pin_d.scl = 1'b1;
            ent_units = 3'd2;
          end
          SWrFall: begin
            pin_d.scl = 1'b0;
            ent_units = 3'd2;
          end
          SAkRel: begin
            pin_d     = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
            ent_units = 3'd1;
          end
          SAkHi: begin
            pin_d.scl = 1'b1;
            ent_units = 3'd1;
          end
          SAkPoll: begin
            poll_d    = 10'd0;
            ent_units = 3'd0;
          end
          SRdLo: begin
            pin_d     = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
            ent_units = 3'd2;
          end
          SRdHi: begin
            pin_d.scl = 1'b1;
            shift_d   = {shift_d[6:0], item_i.sda_in};
            ent_units = 3'd1;
          end
          SRaLo: begin
            pin_d     = '{drv: 1'b1, sda: ~ackc_d, scl: 1'b0};
            ent_units = 3'd2;
          end
          SRaHi: begin
            pin_d.scl = 1'b1;
            ent_units = 3'd2;
          end
          default: ;
        endcase
        state_d = ent_step;
        units_d = ent_units;
        tick_d  = 10'd0;
      end
    end
  end

  always_comb begin
    res_o.scl_level = pin_d.scl;
    res_o.sda_level = pin_d.drv ? pin_d.sda : 1'b1;
    res_o.sda_drive = pin_d.drv;
    res_o.busy_res  = (state_d != SIdle);
    res_o.done_res  = fin;
    res_o.rx_byte   = rx_d;
    res_o.ack_fail  = aerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      bc_q    <= 4'd0;
      tick_q  <= 10'd0;
      units_q <= 3'd0;
      shift_q <= 8'd0;
      poll_q  <= 10'd0;
      pin_q   <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
      rx_q    <= 8'd0;
      aerr_q  <= 1'b0;
      ackc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bc_q    <= bc_d;
      tick_q  <= tick_d;
      units_q <= units_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      pin_q   <= pin_d;
      rx_q    <= rx_d;
      aerr_q  <= aerr_d;
      ackc_q  <= ackc_d;
    end
  end

  `I2CBS_ASSERT_NOW(a_done_ends_seq, clk_i, rst_ni, res_o.done_res, (state_q != SIdle) && !res_o.busy_res, "done without a running sequence")
  `I2CBS_ASSERT_NOW(a_poll_bound, clk_i, rst_ni, state_q == SAkPoll, poll_q <= ack_timeout_i, "ack poll count past timeout")
  `I2CBS_ASSERT_NOW(a_bit_count_range, clk_i, rst_ni, 1'b1, bc_q <= 4'd8, "bit count past eight")
  `I2CBS_ASSERT_NOW(a_sda_released, clk_i, rst_ni, (state_q == SAkRel) || (state_q == SAkHi) || (state_q == SAkPoll) || (state_q == SRdLo) || (state_q == SRdHi), !pin_q.drv, "sda driven while slave owns it")

endmodule

// File: rtl/core/i2c_master_byte_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_core
// tick-driven i2c master byte controller: start, stop, write with ack wait,
// read with ack or nack, one input beat per bus tick
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   s_axis    in         tick beat: op, tx_byte, send_ack, sda_in
//   m_axis    out        pin levels and status for that tick
//   apb       in/out     ticks_per_us (addr 0), ack_timeout (addr 4)
//
// every beat is one tick of the pin sequencer; it is registered, stepped
// through the sequencer logic once the output register can take it, and its
// result lands in that register; a new beat can be taken every cycle while
// m_axis does not stall
// the input and output registers are the only buffers: the input stage moves
// on as soon as the output register is empty or being drained, so a stall on
// m_axis holds s_axis after at most one beat
// reset is asynchronous, active low; registers come up at 50 and 250, the
// bus pins at scl high, sda high and driven
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side tick beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  input  logic [2:0]  s_axis_tuser,   // op[2:0]
  // master side result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                      // busy_res[3], done_res[4], rx_byte[12:5],
                                      // ack_fail[13], zero[15:14]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cbs_pkg::*;

  logic       in_v_q;
  item_t      in_item_q;
  logic       out_v_q;
  result_t    out_res_q;
  result_t    res;
  logic       adv;
  logic [9:0] ticks_per_us;
  logic [9:0] ack_timeout;

  // the registered beat advances into the sequencer when the output
  // register can take its result
  assign adv           = in_v_q & (~out_v_q | m_axis_tready);
  assign s_axis_tready = ~in_v_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op       <= s_axis_tuser;
      in_item_q.tx_byte  <= s_axis_tdata[7:0];
      in_item_q.send_ack <= s_axis_tdata[8];
      in_item_q.sda_in   <= s_axis_tdata[9];
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  i2cbs_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ticks_per_us_o (ticks_per_us),
    .ack_timeout_o  (ack_timeout)
  );

  // sequencer state moves one tick per advanced beat
  i2cbs_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .item_i         (in_item_q),
    .ticks_per_us_i (ticks_per_us),
    .ack_timeout_i  (ack_timeout),
    .res_o          (res)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.ack_fail,
                          out_res_q.rx_byte,
                          out_res_q.done_res,
                          out_res_q.busy_res,
                          out_res_q.sda_drive,
                          out_res_q.sda_level,
                          out_res_q.scl_level};

endmodule

// File: tb/i2c_master_byte_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_core_tb
// drives tick beats with commands and a modeled slave on sda, predicts every
// result beat with a cycle model of the pin sequencer and compares field by
// field; the registers are written over apb between phases and read back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_core_tb;
  import i2cbs_pkg::*;

  // op values past read act as none
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // slave never pulls sda low in the ack wait
  localparam int AckNever = 1 << 20;
  // read data driven by the slave: fixed low, fixed high or random
  localparam int RdLow    = 0;
  localparam int RdHigh   = 1;
  localparam int RdRandom = 2;

  typedef enum logic [4:0] {
    StIdle, StStA, StStB, StSpA, StSpB,
    StWrLo, StWrHi, StWrFall,
    StAkRel, StAkHi, StAkPoll,
    StRdLo, StRdHi, StRaLo, StRaHi
  } bus_step_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  logic [2:0]  s_axis_tuser = '0;   // op[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // scl_level[0], sda_level[1], sda_drive[2],
                                    // busy_res[3], done_res[4], rx_byte[12:5],
                                    // ack_fail[13], zero[15:14]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_sequencer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // sequencer model: registers, step state, pins and the status outputs
  // --------------------------------------------------------------------------
  logic [9:0] ticks_cfg = TicksPerUsReset;
  logic [9:0] ack_limit = AckTimeoutReset;

  bus_step_e  step = StIdle;
  logic [3:0] bit_cnt = '0;
  logic [9:0] tick_cnt = '0;
  logic [2:0] units_left = '0;
  logic [7:0] shift = '0;
  logic [9:0] poll_cnt = '0;
  pins_t      pins = 3'b111;        // scl high, sda high, driven
  logic [7:0] rx_hold = '0;
  logic       ack_err = 1'b0;
  logic       ack_sel = 1'b0;
  logic       cmd_done = 1'b0;

  result_t    expected_pins[$];

  // stimulus and bookkeeping
  int         err_count = 0;
  int         ticks_sent = 0;
  int         ack_delay = 0;       // high polls the slave gives before its ack
  int         rd_force = RdRandom;
  logic       src_idle = 1'b0;
  logic       sink_idle = 1'b0;
  int         stall_left = 0;
  result_t    want_res;
  result_t    got_res;

  function automatic void end_cmd();
    step       = StIdle;
    units_left = '0;
    tick_cnt   = '0;
    cmd_done   = 1'b1;
  endfunction

  // enter a pin phase: set the pins and load its length in delay units
  function automatic void enter_step(bus_step_e nxt, logic sda);
    logic [2:0] units;
    units = 3'd0;
    case (nxt)
      StStA: begin
        pins = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
        units = 3'd4;
      end
      StStB: begin
        pins = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
        units = 3'd4;
      end
      StSpA: begin
        pins = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
        units = 3'd4;
      end
      StSpB: begin
        pins = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
        units = 3'd4;
      end
      StWrLo: begin
        // data bit goes out msb first while scl is low
        pins = '{drv: 1'b1, sda: shift[7], scl: 1'b0};
        shift = {shift[6:0], 1'b0};
        units = 3'd2;
      end
      StWrHi: begin
        pins.scl = 1'b1;
        units = 3'd2;
      end
      StWrFall: begin
        pins.scl = 1'b0;
        units = 3'd2;
      end
      StAkRel: begin
        pins = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
        units = 3'd1;
      end
      StAkHi: begin
        pins.scl = 1'b1;
        units = 3'd1;
      end
      StAkPoll: begin
        poll_cnt = '0;
      end
      StRdLo: begin
        pins = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
        units = 3'd2;
      end
      StRdHi: begin
        // read bit is taken on the tick scl rises
        pins.scl = 1'b1;
        shift = {shift[6:0], sda};
        units = 3'd1;
      end
      StRaLo: begin
        pins = '{drv: 1'b1, sda: ~ack_sel, scl: 1'b0};
        units = 3'd2;
      end
      StRaHi: begin
        pins.scl = 1'b1;
        units = 3'd2;
      end
      default: ;
    endcase
    step       = nxt;
    units_left = units;
    tick_cnt   = '0;
  endfunction

  // the current phase has run out
  function automatic void advance_step(logic sda);
    case (step)
      StStA:  enter_step(StStB, sda);
      StStB: begin
        pins.scl = 1'b0;
        end_cmd();
      end
      StSpA:  enter_step(StSpB, sda);
      StSpB:  end_cmd();
      StWrLo: enter_step(StWrHi, sda);
      StWrHi: enter_step(StWrFall, sda);
      StWrFall: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_step(bit_cnt < 4'd8 ? StWrLo : StAkRel, sda);
      end
      StAkRel: enter_step(StAkHi, sda);
      StAkHi:  enter_step(StAkPoll, sda);
      StRdLo:  enter_step(StRdHi, sda);
      StRdHi: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_step(bit_cnt < 4'd8 ? StRdLo : StRaLo, sda);
      end
      StRaLo: enter_step(StRaHi, sda);
      StRaHi: begin
        pins.scl = 1'b0;
        rx_hold = shift;
        end_cmd();
      end
      default: end_cmd();
    endcase
  endfunction

  // one tick of the sequencer; returns the result beat it must produce
  function automatic result_t predict_pins(item_t it);
    result_t    r;
    logic [9:0] tpu;
    cmd_done = 1'b0;
    if (step == StIdle) begin
      bit_cnt = '0;
      case (it.op)
        OpStart: enter_step(StStA, it.sda_in);
        OpStop:  enter_step(StSpA, it.sda_in);
        OpWrite: begin
          shift = it.tx_byte;
          enter_step(StWrLo, it.sda_in);
        end
        OpRead: begin
          ack_sel = it.send_ack;
          shift = '0;
          enter_step(StRdLo, it.sda_in);
        end
        default: ;
      endcase
    end else if (step == StAkPoll) begin
      if (!it.sda_in) begin
        pins.scl = 1'b0;
        ack_err = 1'b0;
        end_cmd();
      end else if (poll_cnt >= ack_limit) begin
        // no ack in time: flag it and release the bus with a stop
        ack_err = 1'b1;
        enter_step(StSpA, it.sda_in);
      end else begin
        poll_cnt = poll_cnt + 10'd1;
      end
    end else begin
      tpu = (ticks_cfg == '0) ? 10'd1 : ticks_cfg;
      tick_cnt = tick_cnt + 10'd1;
      if (tick_cnt >= tpu) begin
        tick_cnt = '0;
        if (units_left != '0) units_left = units_left - 3'd1;
        if (units_left == '0) advance_step(it.sda_in);
      end
    end
    r.scl_level = pins.scl;
    r.sda_level = pins.drv ? pins.sda : 1'b1;
    r.sda_drive = pins.drv;
    r.busy_res  = (step != StIdle);
    r.done_res  = cmd_done;
    r.rx_byte   = rx_hold;
    r.ack_fail  = ack_err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // modeled slave: holds sda high for ack_delay polls, then acks; read data
  // and sda outside the ack wait follow rd_force
  // --------------------------------------------------------------------------
  function automatic logic slave_sda();
    if (step == StAkPoll) begin
      if (ack_delay == 0) return 1'b0;
      ack_delay--;
      return 1'b1;
    end
    if (rd_force == RdLow) return 1'b0;
    if (rd_force == RdHigh) return 1'b1;
    return 1'($urandom);
  endfunction

  // mostly an ack within the limit, now and then one just past it
  function automatic int pick_ack_delay();
    if ($urandom_range(0, 5) == 0) return int'(ack_limit) + $urandom_range(1, 3);
    return $urandom_range(0, ack_limit);
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // beat driver: optional idle burst, then hold tvalid until the beat is taken
  // --------------------------------------------------------------------------
  task automatic send_tick(item_t it);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {6'd0, it.sda_in, it.send_ack, it.tx_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pins.push_back(predict_pins(it));
    ticks_sent++;
  endtask

  // issue one command, then keep ticking until the sequencer is idle again;
  // ticks while busy carry random ops that must be ignored
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack, int polls);
    item_t it;
    ack_delay   = polls;
    it.op       = op;
    it.tx_byte  = tx;
    it.send_ack = ack;
    it.sda_in   = slave_sda();
    send_tick(it);
    while (step != StIdle) begin
      it.op       = 3'($urandom_range(0, 7));
      it.tx_byte  = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in   = slave_sda();
      send_tick(it);
    end
  endtask

  // idle ticks with none or an unused op
  task automatic idle_ticks(int n);
    item_t it;
    repeat (n) begin
      it.op       = $urandom_range(0, 1) ? OpNone : 3'($urandom_range(OpSpareLo, OpSpareHi));
      it.tx_byte  = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in   = 1'($urandom);
      send_tick(it);
    end
  endtask

  // stop the stream and let every expected beat come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // apb read of one register, compared against the expected value
  task automatic reg_read(logic idx, logic [9:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {22'd0, want})
      report_mismatch($sformatf("register %0d read %0h expected %0h", idx, prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb write followed by a read back of the same register
  task automatic reg_write(logic idx, logic [9:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {22'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegTicksPerUs) ticks_cfg = val;
    else ack_limit = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_read(idx, val);
  endtask

  task automatic set_regs(logic [9:0] tpu, logic [9:0] ato);
    drain();
    reg_write(RegTicksPerUs, tpu);
    reg_write(RegAckTimeout, ato);
  endtask

  // --------------------------------------------------------------------------
  // result sink: ready with random stall bursts, driven on the falling edge
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_idle && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 16);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pins.size() == 0) begin
        report_mismatch($sformatf("result beat %0h with nothing expected", m_axis_tdata));
      end else begin
        want_res = expected_pins.pop_front();
        got_res.scl_level = m_axis_tdata[0];
        got_res.sda_level = m_axis_tdata[1];
        got_res.sda_drive = m_axis_tdata[2];
        got_res.busy_res  = m_axis_tdata[3];
        got_res.done_res  = m_axis_tdata[4];
        got_res.rx_byte   = m_axis_tdata[12:5];
        got_res.ack_fail  = m_axis_tdata[13];
        check_field("scl_level", 8'(got_res.scl_level), 8'(want_res.scl_level));
        check_field("sda_level", 8'(got_res.sda_level), 8'(want_res.sda_level));
        check_field("sda_drive", 8'(got_res.sda_drive), 8'(want_res.sda_drive));
        check_field("busy_res",  8'(got_res.busy_res),  8'(want_res.busy_res));
        check_field("done_res",  8'(got_res.done_res),  8'(want_res.done_res));
        check_field("rx_byte",   got_res.rx_byte,       want_res.rx_byte);
        check_field("ack_fail",  8'(got_res.ack_fail),  8'(want_res.ack_fail));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset register values read back, pins idle high, unused ops ignored
  task automatic test_reset_defaults();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    reg_read(RegTicksPerUs, TicksPerUsReset);
    reg_read(RegAckTimeout, AckTimeoutReset);
    idle_ticks(6);
  endtask

  // writes of all-ones and all-zeros bytes, acked at once and at the last
  // allowed poll
  task automatic test_write_ack();
    set_regs(10'd1, 10'd3);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_cmd(OpStart, 8'h00, 1'b0, 0);
    run_cmd(OpWrite, 8'hFF, 1'b0, 0);
    run_cmd(OpWrite, 8'h00, 1'b1, 3);
    run_cmd(OpStop, 8'h00, 1'b0, 0);
  endtask

  // ack wait running out: error set, stop sequence runs, next good ack clears
  // it; zero limit still takes an ack on the first poll and fails on the
  // first high poll
  task automatic test_ack_timeout();
    run_cmd(OpWrite, 8'h5A, 1'b0, AckNever);
    run_cmd(OpWrite, 8'h96, 1'b0, 0);
    set_regs(10'd1, 10'd0);
    run_cmd(OpWrite, 8'h3C, 1'b1, 0);
    run_cmd(OpWrite, 8'hC3, 1'b0, 1);
  endtask

  // reads of all-ones with ack and all-zeros with nack, then random data
  task automatic test_read();
    set_regs(10'd1, 10'd2);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    rd_force = RdHigh;
    run_cmd(OpRead, 8'h00, 1'b1, 0);
    rd_force = RdLow;
    run_cmd(OpRead, 8'hFF, 1'b0, 0);
    rd_force = RdRandom;
    run_cmd(OpRead, 8'h00, 1'b1, 0);
  endtask

  // zero ticks per unit behaves as one; a longer unit stretches a stop
  task automatic test_tick_extremes();
    set_regs(10'd0, 10'd5);
    run_cmd(OpStart, 8'h00, 1'b0, 0);
    run_cmd(OpRead, 8'h00, 1'b0, 0);
    set_regs(10'd6, 10'd5);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_cmd(OpStop, 8'h00, 1'b0, 0);
  endtask

  // random traffic until budget ticks have gone out: mostly whole transfers
  // (start, address, at most one data byte, stop), some lone commands and
  // idle noise
  task automatic run_traffic(int budget);
    int stop_at;
    int kind;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        idle_ticks($urandom_range(1, 4));
      end else if (kind == 1) begin
        run_cmd(3'($urandom_range(OpStart, OpRead)), 8'($urandom), 1'($urandom),
                pick_ack_delay());
      end else begin
        run_cmd(OpStart, 8'($urandom), 1'($urandom), 0);
        run_cmd(OpWrite, 8'($urandom), 1'($urandom), pick_ack_delay());
        repeat ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1))
            run_cmd(OpWrite, 8'($urandom), 1'($urandom), pick_ack_delay());
          else
            run_cmd(OpRead, 8'($urandom), 1'($urandom), 0);
        end
        run_cmd(OpStop, 8'($urandom), 1'($urandom), 0);
      end
    end
  endtask

  // several register settings with random idling, last phase with none
  task automatic test_random_traffic();
    logic [9:0] tpu;
    for (int ph = 0; ph < 3; ph++) begin
      case ($urandom_range(0, 5))
        0:       tpu = 10'd0;
        1:       tpu = 10'd2;
        default: tpu = 10'd1;
      endcase
      set_regs(tpu, 10'($urandom_range(0, 6)));
      src_idle  = 1'($urandom);
      sink_idle = 1'($urandom);
      run_traffic(50);
    end
    set_regs(10'd1, 10'($urandom_range(0, 6)));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_traffic(50);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_write_ack();
    test_ack_timeout();
    test_read();
    test_tick_extremes();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("i2c_master_byte_sequencer_core verification clean");
    end else begin
      $display("i2c_master_byte_sequencer_core verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("i2c_master_byte_sequencer_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/i2cbs_pkg.sv
rtl/core/i2cbs_cfg.sv
rtl/core/i2cbs_seq.sv
rtl/core/i2c_master_byte_sequencer_core.sv
tb/i2c_master_byte_sequencer_core_tb.sv
